### rtl/core/dq_pkg.sv
package dq_pkg;

    localparam int OP_BITS    = 3;
    localparam int FIELD_BITS = 32;
    localparam int COUNT_BITS = 5;

    typedef enum logic [OP_BITS-1:0] {
        OP_NONE       = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4
    } op_e;

    typedef struct packed {
        logic [OP_BITS-1:0]    operation;
        logic [FIELD_BITS-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] popped_value;
        logic                  pop_valid;
        logic [FIELD_BITS-1:0] front_value;
        logic [FIELD_BITS-1:0] back_value;
        logic [COUNT_BITS-1:0] entry_count;
        logic                  is_empty;
        logic                  is_full;
        logic                  rejected;
    } rsp_t;

    // per-cell control from the top level
    typedef struct packed {
        logic shift_in_front;  // push front: take the neighbor nearer the front
        logic shift_to_front;  // pop front: take the neighbor nearer the back
        logic write_here;      // push back lands in this cell
    } cell_ctl_t;

endpackage

### rtl/core/double_ended_queue.sv
// Latency: a result beat passes through the state update and pending result, then
// the response register, and waits longer only while the response side stalls.
// Throughput: one operation per cycle unless the response stalls; all cells update together.
// Reset: rst_n clears the entry count, the pending flag and the response valid at once;
// the cell contents are not reset and are only read once written.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // Words are kept at the stored width; the front entry always sits in cell 0 and the
    // back entry in cell count-1. Pushing at the front shifts the whole row one cell toward
    // the back, popping at the front shifts it toward the front, and pushing at the back
    // loads the first free cell. Popping at the back only drops the count.
    localparam int STORE_W = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int IDX_W   = $clog2(CAPACITY);

    logic [STORE_W-1:0] cell_word [CAPACITY];
    cell_ctl_t          cell_ctl  [CAPACITY];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Pending result: the state update is done, and the report waits here so the front
    // and back words are read from the updated row.
    logic               pend_reg;
    logic               pend_next;
    logic [STORE_W-1:0] pend_popped_reg;
    logic [STORE_W-1:0] pend_popped_next;
    logic               pend_pop_valid_reg;
    logic               pend_pop_valid_next;
    logic               pend_rejected_reg;
    logic               pend_rejected_next;

    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_reg;
    rsp_t rsp_next;

    logic               accept;
    logic               load_rsp;
    logic               is_empty_now;
    logic               is_full_now;
    logic               push_back_ok;
    logic               push_front_ok;
    logic               pop_front_ok;
    logic               pop_back_ok;
    logic               op_rejected;
    logic [STORE_W-1:0] push_word;
    logic [CNT_W-1:0]   back_pos;
    logic [STORE_W-1:0] back_word;
    op_e                op;

    assign is_empty_now = (count_reg == '0);
    assign is_full_now  = (count_reg == CNT_W'(CAPACITY));
    assign push_word    = req.push_value[STORE_W-1:0];

    // one read port on the row, at the back entry; used for pop back at accept time and
    // for the back word when the result is formed
    assign back_pos  = count_reg - CNT_W'(1);
    assign back_word = cell_word[back_pos[IDX_W-1:0]];

    // a new beat may enter when nothing is pending or the pending result can move on this cycle
    assign load_rsp  = pend_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !pend_reg || load_rsp;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        op = op_e'(req.operation);
        push_back_ok  = 1'b0;
        push_front_ok = 1'b0;
        pop_front_ok  = 1'b0;
        pop_back_ok   = 1'b0;
        op_rejected   = 1'b0;
        unique case (op)
            OP_PUSH_BACK:
            begin
                push_back_ok = accept && !is_full_now;
                op_rejected  = is_full_now;
            end
            OP_PUSH_FRONT:
            begin
                push_front_ok = accept && !is_full_now;
                op_rejected   = is_full_now;
            end
            OP_POP_FRONT:
            begin
                pop_front_ok = accept && !is_empty_now;
                op_rejected  = is_empty_now;
            end
            OP_POP_BACK:
            begin
                pop_back_ok = accept && !is_empty_now;
                op_rejected = is_empty_now;
            end
            default:
            begin
                // no operation, including the unused codes
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (push_back_ok || push_front_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_front_ok || pop_back_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // pending fields are captured only on accept and held while the result waits
    always_comb
    begin
        pend_next           = pend_reg;
        pend_popped_next    = pend_popped_reg;
        pend_pop_valid_next = pend_pop_valid_reg;
        pend_rejected_next  = pend_rejected_reg;
        if (accept)
        begin
            pend_next           = 1'b1;
            pend_pop_valid_next = pop_front_ok || pop_back_ok;
            pend_rejected_next  = op_rejected;
            if (pop_front_ok)
            begin
                pend_popped_next = cell_word[0];
            end
            else if (pop_back_ok)
            begin
                pend_popped_next = back_word;
            end
            else
            begin
                pend_popped_next = '0;
            end
        end
        else if (load_rsp)
        begin
            pend_next = 1'b0;
        end
    end

    // result from the updated row
    always_comb
    begin
        rsp_next              = rsp_reg;
        rsp_valid_next        = rsp_valid_reg;
        if (load_rsp)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.popped_value = FIELD_BITS'(pend_popped_reg);
            rsp_next.pop_valid    = pend_pop_valid_reg;
            rsp_next.front_value  = is_empty_now ? '0 : FIELD_BITS'(cell_word[0]);
            rsp_next.back_value   = is_empty_now ? '0 : FIELD_BITS'(back_word);
            rsp_next.entry_count  = COUNT_BITS'(count_reg);
            rsp_next.is_empty     = is_empty_now;
            rsp_next.is_full      = is_full_now;
            rsp_next.rejected     = pend_rejected_reg;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // the row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [STORE_W-1:0] front_nb;
        logic [STORE_W-1:0] back_nb;

        if (i == 0)
        begin : g_head
            assign front_nb = push_word;
        end
        else
        begin : g_mid
            assign front_nb = cell_word[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign back_nb = '0;
        end
        else
        begin : g_body
            assign back_nb = cell_word[i+1];
        end

        assign cell_ctl[i].shift_in_front = push_front_ok;
        assign cell_ctl[i].shift_to_front = pop_front_ok;
        assign cell_ctl[i].write_here     = push_back_ok && (count_reg == CNT_W'(i));

        dq_cell #(
            .W (STORE_W)
        ) u_cell (
            .clk        (clk),
            .ctl        (cell_ctl[i]),
            .from_front (front_nb),
            .from_back  (back_nb),
            .push_value (push_word),
            .word       (cell_word[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_popped_reg    <= pend_popped_next;
        pend_pop_valid_reg <= pend_pop_valid_next;
        pend_rejected_reg  <= pend_rejected_next;
        rsp_reg            <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_pends: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pend_reg)
        else $error("accepted beat left no pending result");

    a_pop_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.pop_valid |-> !rsp_reg.rejected && !rsp_reg.is_full)
        else $error("pop reported both done and rejected");

    a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.is_empty |-> rsp_reg.entry_count == '0)
        else $error("empty flag disagrees with count");
`endif

endmodule

### rtl/core/dq_cell.sv
module dq_cell
    import dq_pkg::*;
#(
    parameter int W = 32
) (
    input  logic         clk,
    input  cell_ctl_t    ctl,
    input  logic [W-1:0] from_front,
    input  logic [W-1:0] from_back,
    input  logic [W-1:0] push_value,
    output logic [W-1:0] word
);

    logic [W-1:0] word_reg;
    logic [W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctl.shift_in_front)
        begin
            word_next = from_front;
        end
        else if (ctl.shift_to_front)
        begin
            word_next = from_back;
        end
        else if (ctl.write_here)
        begin
            word_next = push_value;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

### verif/tb.sv
module tb;
    import dq_pkg::*;

    // Depth of the block under test (its CAPACITY default).
    localparam int DEPTH = 16;

    // Codes 5..7 are spare and must behave as a no-op.
    localparam logic [OP_BITS-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_BITS-1:0] OP_SPARE_HI = 3'd7;

    // Abort guard.
    localparam int CYCLE_LIMIT   = 200000;
    // Only the first few bad fields are reported; later ones are still counted.
    localparam int REPORT_CAP    = 30;
    // Beats per idle/stall phase in the random section.
    localparam int PHASE_BEATS   = 385;
    // The push/pop mix is re-chosen after this many beats.
    localparam int BIAS_SPAN     = 48;
    // Settle time after the last result, with margin.
    localparam int SETTLE_CYCLES = 8;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    double_ended_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // One row of the directed section. If has_lit is set, lit_status is the
    // status typed in by hand and it takes the place of the prediction.
    typedef struct packed {
        req_t stim;
        logic has_lit;
        rsp_t lit_status;
    } step_row_t;

    // Shadow copy of the deque: ring of words, head/tail slots, fill level.
    // The 4-bit indices wrap around the 16-entry ring by themselves.
    logic [FIELD_BITS-1:0] shadow_ring [DEPTH];
    logic [3:0]            shadow_head = '0;
    logic [3:0]            shadow_tail = '0;
    logic [COUNT_BITS-1:0] shadow_fill = '0;

    // Status beats not yet returned by the block, oldest first.
    rsp_t      awaited_status [$];
    step_row_t directed_steps [$];

    // Idle/stall knobs, in percent, changed per phase.
    int gap_pct   = 0;
    int stall_pct = 0;

    int errors        = 0;
    int cycle_count   = 0;
    int beats_sent    = 0;
    int beats_checked = 0;
    int full_hits     = 0;
    int push_refused  = 0;
    int pop_refused   = 0;

    // Status beat built from its fields, for the hand-typed rows.
    function automatic rsp_t status_of(logic [FIELD_BITS-1:0] popped, logic took,
                                       logic [FIELD_BITS-1:0] head_word,
                                       logic [FIELD_BITS-1:0] tail_word,
                                       logic [COUNT_BITS-1:0] fill,
                                       logic none_left, logic no_room, logic refused);
        rsp_t s;
        s.popped_value = popped;
        s.pop_valid    = took;
        s.front_value  = head_word;
        s.back_value   = tail_word;
        s.entry_count  = fill;
        s.is_empty     = none_left;
        s.is_full      = no_room;
        s.rejected     = refused;
        return s;
    endfunction

    // Applies one operation to the shadow deque and returns the status the
    // block must report for it.
    function automatic rsp_t predict_deque_step(req_t r);
        rsp_t s;
        s = '0;
        case (r.operation)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (shadow_fill == COUNT_BITS'(DEPTH))
                begin
                    s.rejected = 1'b1;
                end
                else
                begin
                    // The first word lands in the head slot from either end.
                    if (shadow_fill == '0)
                        shadow_tail = shadow_head;
                    else if (r.operation == OP_PUSH_BACK)
                        shadow_tail = shadow_tail + 4'd1;
                    else
                        shadow_head = shadow_head - 4'd1;
                    if (r.operation == OP_PUSH_BACK)
                        shadow_ring[shadow_tail] = r.push_value;
                    else
                        shadow_ring[shadow_head] = r.push_value;
                    shadow_fill = shadow_fill + 1'b1;
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (shadow_fill == '0)
                begin
                    s.rejected = 1'b1;
                end
                else
                begin
                    s.pop_valid = 1'b1;
                    if (r.operation == OP_POP_FRONT)
                    begin
                        s.popped_value = shadow_ring[shadow_head];
                        if (shadow_fill > 1)
                            shadow_head = shadow_head + 4'd1;
                    end
                    else
                    begin
                        s.popped_value = shadow_ring[shadow_tail];
                        if (shadow_fill > 1)
                            shadow_tail = shadow_tail - 4'd1;
                    end
                    shadow_fill = shadow_fill - 1'b1;
                    if (shadow_fill == '0)
                        shadow_tail = shadow_head;
                end
            end
            default:
            begin
                // none and the spare codes leave everything as it is
            end
        endcase
        if (shadow_fill != '0)
        begin
            s.front_value = shadow_ring[shadow_head];
            s.back_value  = shadow_ring[shadow_tail];
        end
        s.entry_count = shadow_fill;
        s.is_empty    = (shadow_fill == '0);
        s.is_full     = (shadow_fill == COUNT_BITS'(DEPTH));
        return s;
    endfunction

    // Data words: mostly random, with the all-zero and all-one words mixed in.
    function automatic logic [FIELD_BITS-1:0] rand_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(logic [OP_BITS-1:0] op, logic [FIELD_BITS-1:0] word,
                           logic has_lit, rsp_t lit_status);
        step_row_t row;
        row.stim.operation  = op;
        row.stim.push_value = word;
        row.has_lit         = has_lit;
        row.lit_status      = lit_status;
        directed_steps.push_back(row);
    endtask

    // Drives one request beat and returns on the edge that takes it. The
    // sender may first idle for a random number of cycles. valid is raised
    // only once per step and is held until the beat is taken.
    task automatic send_beat(req_t r, logic has_lit, rsp_t lit_status);
        rsp_t predicted;
        while ($urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = predict_deque_step(r);
        awaited_status.push_back(has_lit ? lit_status : predicted);
        beats_sent++;
        if (predicted.is_full)
            full_hits++;
        if (predicted.rejected && predicted.is_full)
            push_refused++;
        if (predicted.rejected && predicted.is_empty)
            pop_refused++;
    endtask

    // Sender holds off until every expected status has come back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (awaited_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(string name, logic [FIELD_BITS-1:0] want,
                               logic [FIELD_BITS-1:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= REPORT_CAP)
                $display("%0t: %s expected %h, actual %h", $realtime, name, want, got);
        end
    endtask

    // Receiver: ready is re-drawn every cycle against the current stall rate.
    always @(posedge clk)
        rsp_ready <= ($urandom_range(99) >= stall_pct);

    // Abort guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run stopped after %0d cycles, %0d status beats outstanding",
                     $realtime, cycle_count, awaited_status.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side. Signals are read right after the edge, so these are the
    // values the edge itself saw.
    always @(posedge clk)
    begin : status_check
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_status.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: status beat with nothing pending, actual %h",
                             $realtime, rsp);
            end
            else
            begin
                want = awaited_status.pop_front();
                beats_checked++;
                check_field("popped_value", want.popped_value, rsp.popped_value);
                check_field("pop_valid",    FIELD_BITS'(want.pop_valid),
                            FIELD_BITS'(rsp.pop_valid));
                check_field("front_value",  want.front_value, rsp.front_value);
                check_field("back_value",   want.back_value, rsp.back_value);
                check_field("entry_count",  FIELD_BITS'(want.entry_count),
                            FIELD_BITS'(rsp.entry_count));
                check_field("is_empty",     FIELD_BITS'(want.is_empty),
                            FIELD_BITS'(rsp.is_empty));
                check_field("is_full",      FIELD_BITS'(want.is_full),
                            FIELD_BITS'(rsp.is_full));
                check_field("rejected",     FIELD_BITS'(want.rejected),
                            FIELD_BITS'(rsp.rejected));
            end
        end
    end

    initial
    begin : stimulus
        int gap_plan   [4];
        int stall_plan [4];
        int push_pct;
        int pick;
        req_t r;

        gap_plan   = '{0, 50, 0, 37};
        stall_plan = '{0, 0, 50, 37};
        push_pct   = 50;

        // Directed table. Hand-typed status only where it is obvious: the
        // empty deque after reset, the all-one/all-zero words at both ends and
        // pops that refuse. Every other row goes through the predictor.
        add_row(OP_POP_FRONT,  rand_word(), 1'b1,
                status_of('0, 1'b0, '0, '0, '0, 1'b1, 1'b0, 1'b1));
        add_row(OP_POP_BACK,   rand_word(), 1'b1,
                status_of('0, 1'b0, '0, '0, '0, 1'b1, 1'b0, 1'b1));
        add_row(OP_NONE,       rand_word(), 1'b1,
                status_of('0, 1'b0, '0, '0, '0, 1'b1, 1'b0, 1'b0));
        add_row(OP_PUSH_BACK,  '1,          1'b1,
                status_of('0, 1'b0, '1, '1, COUNT_BITS'(1), 1'b0, 1'b0, 1'b0));
        add_row(OP_PUSH_FRONT, '0,          1'b1,
                status_of('0, 1'b0, '0, '1, COUNT_BITS'(2), 1'b0, 1'b0, 1'b0));
        // spare code: must not touch the deque
        add_row(OP_SPARE_HI,   rand_word(), 1'b0, '0);
        add_row(OP_POP_FRONT,  rand_word(), 1'b1,
                status_of('0, 1'b1, '1, '1, COUNT_BITS'(1), 1'b0, 1'b0, 1'b0));
        add_row(OP_POP_BACK,   rand_word(), 1'b1,
                status_of('1, 1'b1, '0, '0, '0, 1'b1, 1'b0, 1'b0));
        // Fill from both ends so the head index wraps, then push into a full deque.
        for (int i = 0; i < DEPTH; i++)
            add_row((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, rand_word(), 1'b0, '0);
        add_row(OP_PUSH_BACK,  rand_word(), 1'b0, '0);
        add_row(OP_PUSH_FRONT, rand_word(), 1'b0, '0);

        // Reset: held low at the start, released on an edge.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
            send_beat(directed_steps[i].stim, directed_steps[i].has_lit,
                      directed_steps[i].lit_status);
        wait_drained();

        // Random section: one phase per idle/stall setting. Each span of
        // beats leans toward pushes, pops or neither, so the fill level sweeps
        // from empty to full and back, with refusals at both ends.
        for (int ph = 0; ph < 4; ph++)
        begin
            gap_pct   = gap_plan[ph];
            stall_pct = stall_plan[ph];
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if (n % BIAS_SPAN == 0)
                begin
                    case ($urandom_range(2))
                        0: push_pct = 85;
                        1: push_pct = 50;
                        default: push_pct = 15;
                    endcase
                end
                pick = $urandom_range(99);
                r.push_value = rand_word();
                if (pick < 3)
                    r.operation = OP_NONE;
                else if (pick < 6)
                    r.operation = OP_BITS'(OP_SPARE_LO + $urandom_range(2));
                else if ($urandom_range(99) < push_pct)
                    r.operation = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                else
                    r.operation = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
                send_beat(r, 1'b0, '0);
            end
            // Pressure point: sender stops until the deque's answers catch up.
            wait_drained();
        end

        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d operations over four idle/stall mixes; %0d status beats checked.",
                 beats_sent, beats_checked);
        $display("Deque was full after %0d operations; refused %0d pushes and %0d pops.",
                 full_hits, push_refused, pop_refused);
        if (errors == 0 && awaited_status.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
